// File: src/smp_pkg.sv
`timescale 1ns / 1ps

package smp_pkg;

    localparam int LANE_W         = 16;
    localparam int LANES_DEF      = 4;
    localparam int LINE_DEPTH_DEF = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int COUNT_W    = 26;

    // Upper bounds of the configuration registers
    localparam logic [10:0] GROUPS_MAX = 11'd256;
    localparam logic [10:0] DIM_MAX    = 11'd1024;
    localparam logic [10:0] COLS_O_MAX = 11'd256;
    localparam logic [10:0] POOL_MAX   = 11'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_GROUPS = 3'd0,
        CFG_ROWS_IN        = 3'd1,
        CFG_COLS_IN        = 3'd2,
        CFG_ROWS_OUT       = 3'd3,
        CFG_COLS_OUT       = 3'd4,
        CFG_POOL_X         = 3'd5,
        CFG_POOL_Y         = 3'd6
    } cfg_reg_t;

    // Zero reads as one, anything above the bound reads as the bound
    function automatic logic [10:0] clamp_cfg(input logic [10:0] v, input logic [10:0] hi);
        logic [10:0] r;
        if (v == 11'd0) begin
            r = 11'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [LANE_W-1:0] lane_max(input logic signed [LANE_W-1:0] a,
                                                          input logic signed [LANE_W-1:0] b);
        return (a >= b) ? a : b;
    endfunction

    // True when v is a multiple of p, p in 1..4. Multiples of three use the
    // base-4 digit sum, since 4 = 1 mod 3.
    function automatic logic is_multiple(input logic [10:0] v, input logic [2:0] p);
        logic [11:0] vp;
        logic [4:0]  s;
        logic        res;
        vp = {1'b0, v};
        s  = 5'd0;
        for (int i = 0; i < 6; i++) begin
            s = s + 5'(vp[2*i +: 2]);
        end
        if (s >= 5'd9) begin
            s = s - 5'd9;
        end
        if (s >= 5'd6) begin
            s = s - 5'd6;
        end
        if (s >= 5'd3) begin
            s = s - 5'd3;
        end
        case (p)
            3'd2:    res = ~v[0];
            3'd3:    res = (s == 5'd0);
            3'd4:    res = (v[1:0] == 2'b00);
            default: res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

// File: src/smp_line_ram.sv
`timescale 1ns / 1ps

module smp_line_ram
    import smp_pkg::*;
#(
    parameter int DEPTH = LINE_DEPTH_DEF,
    parameter int WIDTH = LANE_W * LANES_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/stream_max_pool_2d.sv
`timescale 1ns / 1ps
// Sequencing: an item that completes a result goes straight to S_OUT when pool_y is 1; otherwise S_ADDR
//   (read) and S_MAX (compare) alternate over the pool_y-1 rows above, through the single read port of
//   the line buffer, with an extra S_ADDR step each time an address wraps below zero. Items are taken
//   only in S_IDLE, so none is taken while a result is formed and until S_OUT has handed it over.
// Reset (aresetn low, synchronous): counters, ring pointer and recent words clear, registers
//   return to 1. The line buffer is not cleared; entries are read only after being written.

module stream_max_pool_2d
    import smp_pkg::*;
#(
    parameter int LANES      = LANES_DEF,
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    // input item channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [LANE_W-1:0]     s_lane_in_0,
    input  logic signed [LANE_W-1:0]     s_lane_in_1,
    input  logic signed [LANE_W-1:0]     s_lane_in_2,
    input  logic signed [LANE_W-1:0]     s_lane_in_3,

    // result item channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [LANE_W-1:0]     m_lane_out_0,
    output logic signed [LANE_W-1:0]     m_lane_out_1,
    output logic signed [LANE_W-1:0]     m_lane_out_2,
    output logic signed [LANE_W-1:0]     m_lane_out_3,
    output logic                         m_frame_end
);

    localparam int AW = $clog2(LINE_DEPTH);
    // signed width for ring address arithmetic: holds -256 and LINE_DEPTH
    localparam int SW = ((AW > 9) ? AW : 9) + 2;
    localparam int W  = LANE_W * LANES;

    typedef logic [LANES-1:0][LANE_W-1:0] word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_MAX,
        S_OUT
    } state_t;

    function automatic word_t word_max(input word_t a, input word_t b);
        word_t r;
        for (int k = 0; k < LANES; k++) begin
            r[k] = lane_max(a[k], b[k]);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers, held as written (low bits only for the narrower ones), clamped on use
    // ------------------------------------------------------------------
    logic [8:0]  cg_reg;
    logic [10:0] ri_reg;
    logic [10:0] ci_reg;
    logic [10:0] ro_reg;
    logic [8:0]  co_reg;
    logic [2:0]  px_reg;
    logic [2:0]  py_reg;
    logic [1:0]  settle_reg;

    logic        cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cg_reg     <= 9'd1;
            ri_reg     <= 11'd1;
            ci_reg     <= 11'd1;
            ro_reg     <= 11'd1;
            co_reg     <= 9'd1;
            px_reg     <= 3'd1;
            py_reg     <= 3'd1;
            settle_reg <= 2'd0;
        end else begin
            if (cfg_wr) begin
                // hold results back until the frame-size product has settled through area_reg and last_idx_reg
                settle_reg <= 2'd2;
                case (cfg_index)
                    CFG_CHANNEL_GROUPS: cg_reg <= cfg_data[8:0];
                    CFG_ROWS_IN:        ri_reg <= cfg_data;
                    CFG_COLS_IN:        ci_reg <= cfg_data;
                    CFG_ROWS_OUT:       ro_reg <= cfg_data;
                    CFG_COLS_OUT:       co_reg <= cfg_data[8:0];
                    CFG_POOL_X:         px_reg <= cfg_data[2:0];
                    CFG_POOL_Y:         py_reg <= cfg_data[2:0];
                    default:            ;
                endcase
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    logic [8:0]  cg_c;
    logic [10:0] ri_c;
    logic [10:0] ci_c;
    logic [10:0] ro_c;
    logic [8:0]  co_c;
    logic [2:0]  px_c;
    logic [2:0]  py_c;

    assign cg_c = 9'(clamp_cfg(11'(cg_reg), GROUPS_MAX));
    assign ri_c = clamp_cfg(ri_reg, DIM_MAX);
    assign ci_c = clamp_cfg(ci_reg, DIM_MAX);
    assign ro_c = clamp_cfg(ro_reg, DIM_MAX);
    assign co_c = 9'(clamp_cfg(11'(co_reg), COLS_O_MAX));
    assign px_c = 3'(clamp_cfg(11'(px_reg), POOL_MAX));
    assign py_c = 3'(clamp_cfg(11'(py_reg), POOL_MAX));

    // Results per frame minus one, in two registered multiply stages
    logic [18:0]        area_reg;
    logic [COUNT_W-1:0] last_idx_reg;
    logic [26:0]        total;

    assign total = 27'(area_reg) * 27'(cg_c);

    always_ff @(posedge aclk) begin
        area_reg     <= 19'(ro_c) * 19'(co_c);
        last_idx_reg <= COUNT_W'(total - 27'd1);
    end

    // ------------------------------------------------------------------
    // Input word and horizontal pooling with up to three recent words
    // ------------------------------------------------------------------
    logic signed [LANE_W-1:0] lane_in_arr  [4];
    logic signed [LANE_W-1:0] lane_out_arr [4];
    word_t                    word_in;
    word_t                    recent_reg [3];
    word_t                    hmax1;
    word_t                    hmax2;
    word_t                    h_word;

    assign lane_in_arr[0] = s_lane_in_0;
    assign lane_in_arr[1] = s_lane_in_1;
    assign lane_in_arr[2] = s_lane_in_2;
    assign lane_in_arr[3] = s_lane_in_3;

    // lanes at or above LANES are dropped here
    for (genvar k = 0; k < LANES; k++) begin : g_lane_in
        assign word_in[k] = lane_in_arr[k];
    end

    assign hmax1  = (px_c >= 3'd2) ? word_max(word_in, recent_reg[0]) : word_in;
    assign hmax2  = (px_c >= 3'd3) ? word_max(hmax1, recent_reg[1]) : hmax1;
    assign h_word = (px_c >= 3'd4) ? word_max(hmax2, recent_reg[2]) : hmax2;

    // ------------------------------------------------------------------
    // Raster counters and ring pointer
    // ------------------------------------------------------------------
    logic [9:0]         col_reg;
    logic [9:0]         row_reg;
    logic [7:0]         grp_reg;
    logic [8:0]         pooled_reg;
    logic [AW-1:0]      ring_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [9:0]         col_next;
    logic [9:0]         row_next;
    logic [7:0]         grp_next;
    logic [8:0]         pooled_next;
    logic [AW-1:0]      ring_next;
    logic [COUNT_W-1:0] count_next;

    logic [10:0]        col_inc;
    logic [10:0]        row_inc;
    logic [8:0]         grp_inc;
    logic               wr_hit;
    logic               out_hit;

    always_comb begin
        col_inc     = {1'b0, col_reg} + 11'd1;
        row_inc     = {1'b0, row_reg} + 11'd1;
        grp_inc     = {1'b0, grp_reg} + 9'd1;
        wr_hit      = is_multiple(col_inc, px_c) && (pooled_reg < co_c);
        out_hit     = wr_hit && is_multiple(row_inc, py_c);

        col_next    = col_reg;
        row_next    = row_reg;
        grp_next    = grp_reg;
        pooled_next = pooled_reg;
        ring_next   = ring_reg;
        count_next  = count_reg;

        if (wr_hit) begin
            ring_next   = (ring_reg == AW'(LINE_DEPTH - 1)) ? '0 : ring_reg + AW'(1);
            pooled_next = pooled_reg + 9'd1;
        end
        if (out_hit && (count_reg != '1)) begin
            count_next = count_reg + COUNT_W'(1);
        end

        // end of row, end of group plane, end of frame
        if (col_inc >= ci_c) begin
            col_next    = '0;
            pooled_next = '0;
            if (row_inc >= ri_c) begin
                row_next = '0;
                if (grp_inc >= cg_c) begin
                    grp_next   = '0;
                    ring_next  = '0;
                    count_next = '0;
                end else begin
                    grp_next = grp_inc[7:0];
                end
            end else begin
                row_next = row_inc[9:0];
            end
        end else begin
            col_next = col_inc[9:0];
        end
    end

    // ------------------------------------------------------------------
    // Line buffer
    // ------------------------------------------------------------------
    state_t             state_reg;
    logic [SW-1:0]      addr_reg;
    logic [1:0]         left_reg;
    word_t              acc_reg;
    logic [COUNT_W-1:0] snap_reg;
    word_t              out_word_reg;
    logic               m_valid_reg;
    logic               m_frame_end_reg;

    logic               accept;
    logic               wr_en;
    logic               rd_en;
    logic [W-1:0]       rd_data;
    logic               out_free;
    logic               out_load;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid & s_ready;
    // writes happen only on accept, reads only in S_ADDR: a read always sees the latest write
    assign wr_en    = accept & wr_hit;
    assign rd_en    = (state_reg == S_ADDR) & ~addr_reg[SW-1];
    assign out_free = ~m_valid_reg | m_ready;
    // hand over once the output register is free and the frame size has settled
    assign out_load = (state_reg == S_OUT) & out_free & (settle_reg == 2'd0);

    smp_line_ram #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ring_reg),
        .wr_data (W'(h_word)),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer: accept, walk back pool_y-1 rows in the ring, deliver
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            grp_reg     <= '0;
            pooled_reg  <= '0;
            ring_reg    <= '0;
            count_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                recent_reg[i] <= '0;
            end
        end else begin
            // load a new result, or drop the current one once taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        recent_reg[2] <= recent_reg[1];
                        recent_reg[1] <= recent_reg[0];
                        recent_reg[0] <= word_in;
                        col_reg       <= col_next;
                        row_reg       <= row_next;
                        grp_reg       <= grp_next;
                        pooled_reg    <= pooled_next;
                        ring_reg      <= ring_next;
                        count_reg     <= count_next;
                        if (out_hit) begin
                            acc_reg  <= h_word;
                            snap_reg <= count_reg;
                            addr_reg <= SW'(ring_reg) - SW'(co_c);
                            left_reg <= 2'(py_c - 3'd1);
                            state_reg <= (py_c == 3'd1) ? S_OUT : S_ADDR;
                        end
                    end
                end

                S_ADDR: begin
                    if (addr_reg[SW-1]) begin
                        // below zero: wrap round the ring
                        addr_reg <= addr_reg + SW'(LINE_DEPTH);
                    end else begin
                        addr_reg  <= addr_reg - SW'(co_c);
                        left_reg  <= left_reg - 2'd1;
                        state_reg <= S_MAX;
                    end
                end

                S_MAX: begin
                    acc_reg   <= word_max(acc_reg, word_t'(rd_data));
                    state_reg <= (left_reg == 2'd0) ? S_OUT : S_ADDR;
                end

                S_OUT: begin
                    // hold until the output register is free and the frame size has settled
                    if (out_load) begin
                        out_word_reg    <= acc_reg;
                        m_frame_end_reg <= (snap_reg == last_idx_reg);
                        state_reg       <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result ports; lanes at or above LANES read as zero
    // ------------------------------------------------------------------
    for (genvar k = 0; k < 4; k++) begin : g_lane_out
        if (k < LANES) begin : g_used
            assign lane_out_arr[k] = out_word_reg[k];
        end else begin : g_unused
            assign lane_out_arr[k] = '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_end  = m_frame_end_reg;
    assign m_lane_out_0 = lane_out_arr[0];
    assign m_lane_out_1 = lane_out_arr[1];
    assign m_lane_out_2 = lane_out_arr[2];
    assign m_lane_out_3 = lane_out_arr[3];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_rw_overlap : assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("line buffer written and read in the same cycle");

    a_rd_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (addr_reg < SW'(LINE_DEPTH)))
        else $error("line buffer read outside the ring");

    a_ring_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        ring_reg <= AW'(LINE_DEPTH - 1))
        else $error("ring pointer beyond line depth");

    a_single_row_out : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && out_hit && (py_c == 3'd1)) |=> (state_reg == S_OUT))
        else $error("single-row pooling did not go straight to output");

endmodule
